[rtl/b64lw_pkg.sv]
// Shared types, constants and the alphabet function of the base64 line-wrap encoder.
`default_nettype none

package b64lw_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned RUN_DEPTH = 8;
  localparam int unsigned LIMIT_W   = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W     = 4;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h3D;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_LIMIT = 2'd0,
    REG_EOL_FIRST  = 2'd1,
    REG_EOL_SECOND = 2'd2,
    REG_EOL_LENGTH = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [LIMIT_W-1:0] line_limit;
    logic [CHAR_W-1:0]  eol_first;
    logic [CHAR_W-1:0]  eol_second;
    logic [1:0]         eol_length;
  } cfg_t;

  // One item's worth of output characters, slot 0 goes out first.
  typedef struct packed {
    logic [RUN_DEPTH-1:0][CHAR_W-1:0] chars;
    logic [CNT_W-1:0]                 cnt;
    logic                             done;
  } run_t;

  // Map a sextet onto the standard alphabet.
  function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] v);
    logic [CHAR_W-1:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/b64lw_cfg.sv]
// Configuration register file of the base64 line-wrap encoder.
`default_nettype none

module b64lw_cfg
  import b64lw_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [LIMIT_W-1:0]   cfg_wdata_i,
  output cfg_t                      cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_limit <= 11'd76;
      cfg_q.eol_first  <= 8'd13;
      cfg_q.eol_second <= 8'd10;
      cfg_q.eol_length <= 2'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_LINE_LIMIT: cfg_q.line_limit <= cfg_wdata_i;
        REG_EOL_FIRST:  cfg_q.eol_first  <= cfg_wdata_i[CHAR_W-1:0];
        REG_EOL_SECOND: cfg_q.eol_second <= cfg_wdata_i[CHAR_W-1:0];
        REG_EOL_LENGTH: cfg_q.eol_length <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/b64lw_enc.sv]
// Input register, group state and character-run builder of the encoder.
`default_nettype none

module b64lw_enc
  import b64lw_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [CHAR_W-1:0] data_byte_i,
  input  wire logic              byte_present_i,
  input  wire logic              message_end_i,
  output logic                   run_valid_o,
  input  wire logic              run_ready_i,
  output run_t                   run_o
);

  logic              item_valid_q;
  logic [CHAR_W-1:0] byte_q;
  logic              present_q;
  logic              end_q;

  logic [15:0]        held_q, held_d, held_n;
  logic [1:0]         fill_q, fill_d, fill_n;
  logic [LIMIT_W-1:0] lcnt_q, lcnt_d, lcnt_inc;

  logic              full, brk, tail, eol_two, take;
  logic [1:0]        n_eol;
  logic [2:0]        base, j;
  logic [CHAR_W-1:0] c1, c2;
  logic [3:0][CHAR_W-1:0] quad;
  logic [CNT_W-1:0]  eol_cnt;
  logic [2:0]        slot;

  always_comb begin
    c1       = held_q[15:8];
    c2       = held_q[7:0];
    full     = present_q && fill_q[1];
    lcnt_inc = lcnt_q + 11'd4;
    brk      = ({1'b0, lcnt_inc} + 12'd3) >= {1'b0, cfg_i.line_limit};

    // Group state after the byte, before any end-of-message flush.
    held_n = held_q;
    fill_n = fill_q;
    if (present_q) begin
      if (fill_q[1]) begin
        held_n = 16'h0000;
        fill_n = 2'd0;
      end else if (fill_q == 2'd1) begin
        held_n = {held_q[15:8], byte_q};
        fill_n = 2'd2;
      end else begin
        held_n = {byte_q, 8'h00};
        fill_n = 2'd1;
      end
    end

    tail = end_q && (fill_n != 2'd0);

    if (full) begin
      quad[0] = b64_char(c1[7:2]);
      quad[1] = b64_char({c1[1:0], c2[7:4]});
      quad[2] = b64_char({c2[3:0], byte_q[7:6]});
      quad[3] = b64_char(byte_q[5:0]);
    end else begin
      quad[0] = b64_char(held_n[15:10]);
      quad[1] = b64_char({held_n[9:8], (fill_n == 2'd2) ? held_n[7:4] : 4'h0});
      quad[2] = (fill_n == 2'd2) ? b64_char({held_n[3:0], 2'b00}) : PAD_CHAR;
      quad[3] = PAD_CHAR;
    end

    // Up to two end-of-line sequences follow the quad.
    n_eol   = {1'b0, full && brk} + {1'b0, end_q};
    eol_two = cfg_i.eol_length[1];
    case (n_eol)
      2'd0:    eol_cnt = 4'd0;
      2'd1:    eol_cnt = eol_two ? 4'd2 : 4'd1;
      default: eol_cnt = eol_two ? 4'd4 : 4'd2;
    endcase

    base = (full || tail) ? 3'd4 : 3'd0;
    for (int i = 0; i < RUN_DEPTH; i++) begin
      slot = 3'(i);
      j    = slot - base;
      if ((full || tail) && !slot[2]) begin
        run_o.chars[slot] = quad[slot[1:0]];
      end else if (eol_two && j[0]) begin
        run_o.chars[slot] = cfg_i.eol_second;
      end else begin
        run_o.chars[slot] = cfg_i.eol_first;
      end
    end
    run_o.cnt  = {1'b0, base} + eol_cnt;
    run_o.done = end_q;

    // Next group state once the item retires.
    held_d = held_n;
    fill_d = fill_n;
    lcnt_d = lcnt_q;
    if (full) begin
      lcnt_d = brk ? '0 : lcnt_inc;
    end
    if (end_q) begin
      held_d = 16'h0000;
      fill_d = 2'd0;
      lcnt_d = '0;
    end
  end

  assign run_valid_o = item_valid_q && (run_o.cnt != '0);
  assign take        = item_valid_q && ((run_o.cnt == '0) || run_ready_i);
  assign in_ready_o  = !item_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      held_q       <= '0;
      fill_q       <= '0;
      lcnt_q       <= '0;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      if (take) begin
        held_q <= held_d;
        fill_q <= fill_d;
        lcnt_q <= lcnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q    <= data_byte_i;
      present_q <= byte_present_i;
      end_q     <= message_end_i;
    end
  end

endmodule

`default_nettype wire

[rtl/b64lw_ser.sv]
// Output shift buffer: sends one character of a run per word.
`default_nettype none

module b64lw_ser
  import b64lw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        run_valid_i,
  output logic             run_ready_o,
  input  wire run_t        run_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [CHAR_W-1:0] out_char_o,
  output logic             run_last_o,
  output logic             message_done_o
);

  logic [RUN_DEPTH-1:0][CHAR_W-1:0] buf_q;
  logic [CNT_W-1:0]                 rem_q;
  logic                             done_q;
  logic                             fire, last;

  assign out_valid_o    = (rem_q != '0);
  assign last           = (rem_q == 4'd1);
  assign fire           = out_valid_o && out_ready_i;
  assign run_ready_o    = !out_valid_o || (fire && last);
  assign out_char_o     = buf_q[0];
  assign run_last_o     = last;
  assign message_done_o = last && done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (run_valid_i && run_ready_o) begin
      rem_q <= run_i.cnt;
    end else if (fire) begin
      rem_q <= rem_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_valid_i && run_ready_o) begin
      buf_q  <= run_i.chars;
      done_q <= run_i.done;
    end else if (fire) begin
      buf_q <= {{CHAR_W{1'b0}}, buf_q[RUN_DEPTH-1:1]};
    end
  end

endmodule

`default_nettype wire

[rtl/base64_line_wrap_encoder.sv]
// Top level of the base64 encoder with line wrapping.
// Input channel: in_valid_i/in_ready_o carry one item per word: a message
// byte (data_byte_i, qualified by byte_present_i) and message_end_i, which
// closes the message. Output channel: out_valid_o/out_ready_i carry one
// character per word; run_last_o marks the last character caused by an
// item, message_done_o the last character of a whole message.
// Every third byte yields four alphabet characters; once the line count,
// those four included, plus three reaches line_limit an end-of-line
// sequence follows. The end of a message flushes leftover bytes as a padded
// tail and always appends end-of-line of one or two characters.
// An item is taken into the input register, built combinationally into a
// run of up to eight characters and loaded into the output shift buffer.
// Throughput is set by the output port, one character per cycle while
// out_ready_i is high. A new item is taken while the previous run drains;
// items that emit nothing retire without waiting for the output port.
// Reset clears the group state, line counter and both valid flags and
// loads the register defaults (76, CR, LF, two end-of-line bytes).
// When the receiver stalls, hold the current character; the run buffer
// and input register fill and then in_ready_o drops.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i
// (0 line_limit, 1 first EOL byte, 2 second EOL byte, 3 EOL length).
`default_nettype none

module base64_line_wrap_encoder
  import b64lw_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [LIMIT_W-1:0]   cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [CHAR_W-1:0]    data_byte_i,
  input  wire logic                 byte_present_i,
  input  wire logic                 message_end_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [CHAR_W-1:0]         out_char_o,
  output logic                      run_last_o,
  output logic                      message_done_o
);

  cfg_t cfg;
  run_t run;
  logic run_valid, run_ready;

  b64lw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Build the full character run of one item.
  b64lw_enc u_enc (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .message_end_i  (message_end_i),
    .run_valid_o    (run_valid),
    .run_ready_i    (run_ready),
    .run_o          (run)
  );

  // Drain the run one word at a time.
  b64lw_ser u_ser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .run_valid_i    (run_valid),
    .run_ready_o    (run_ready),
    .run_i          (run),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_char_o     (out_char_o),
    .run_last_o     (run_last_o),
    .message_done_o (message_done_o)
  );

endmodule

`default_nettype wire

[rtl/b64lw_chk.sv]
// Port-level checker of the base64 line-wrap encoder and its bind.
`default_nettype none

module b64lw_chk
  import b64lw_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [CHAR_W-1:0] out_char_o,
  input wire logic              run_last_o,
  input wire logic              message_done_o
);

  // A word offered must stay offered until taken.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out_valid_o dropped before the word was taken");

  // A stalled word keeps its payload.
  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_char_o) && $stable(run_last_o)
      && $stable(message_done_o))
    else $error("output word changed while stalled");

  // The end of a message is always the end of an item's run.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_done_o |-> run_last_o)
    else $error("message_done_o without run_last_o");

  // Nothing can be ready to send right after reset releases.
  a_reset_empty: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("out_valid_o high right after reset");

endmodule

bind base64_line_wrap_encoder b64lw_chk u_b64lw_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_char_o     (out_char_o),
  .run_last_o     (run_last_o),
  .message_done_o (message_done_o)
);

`default_nettype wire
